FILE: rtl/core/cbps_pkg.sv
// Shared types and constants for the chunked byte pattern search.
// Used by cbps_cell, cbps_row and chunked_byte_pattern_search; no dependencies.
package cbps_pkg;

  localparam int MaxPattern = 64;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int ChunkW     = 32;
  localparam int OffW       = 63;
  localparam int CfgW       = 63;

  localparam logic [OffW-1:0] OffMax = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_APPEND   = 2'd1,
    CMD_HAYSTACK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_MATCH   = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef enum logic {
    REG_CHUNK_SIZE   = 1'b0,
    REG_START_OFFSET = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic win_shift;
    logic pat_shift;
    logic pat_clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/cbps_cell.sv
// One compare cell: one window byte and one pattern byte, both shifting to the neighbor.
// Depends on cbps_pkg.
module cbps_cell (
  input  logic                clk,
  input  logic                rst,
  input  cbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          win_in,
  input  logic [7:0]          pat_in,
  input  logic                pvalid_in,
  output logic [7:0]          win_out,
  output logic [7:0]          pat_out,
  output logic                pvalid_out,
  output logic                hit
);

  logic [7:0] win;
  logic [7:0] pat;
  logic       pvalid;

  always_ff @(posedge clk) begin
    if (ctrl.win_shift) begin
      win <= win_in;
    end
    if (ctrl.pat_shift) begin
      pat <= pat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else if (ctrl.pat_clear) begin
      pvalid <= 1'b0;
    end else if (ctrl.pat_shift) begin
      pvalid <= pvalid_in;
    end
  end

  // compare against the byte entering this slot
  assign hit        = !pvalid || (win_in == pat);
  assign win_out    = win;
  assign pat_out    = pat;
  assign pvalid_out = pvalid;

endmodule

FILE: rtl/core/cbps_row.sv
// Row of compare cells: window and reversed pattern shift through it, all cells compare at once.
// Depends on cbps_pkg and cbps_cell.
module cbps_row (
  input  logic                 clk,
  input  logic                 rst,
  input  cbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]           data_byte,
  output logic                 match_all
);

  logic [7:0] win_q    [cbps_pkg::MaxPattern];
  logic [7:0] pat_q    [cbps_pkg::MaxPattern];
  logic       pvalid_q [cbps_pkg::MaxPattern];
  logic [cbps_pkg::MaxPattern-1:0] hits;

  for (genvar i = 0; i < cbps_pkg::MaxPattern; i++) begin : g_cell
    logic [7:0] win_in;
    logic [7:0] pat_in;
    logic       pvalid_in;

    if (i == 0) begin : g_head
      assign win_in    = data_byte;
      assign pat_in    = data_byte;
      assign pvalid_in = 1'b1;
    end else begin : g_body
      assign win_in    = win_q[i-1];
      assign pat_in    = pat_q[i-1];
      assign pvalid_in = pvalid_q[i-1];
    end

    cbps_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .win_in     (win_in),
      .pat_in     (pat_in),
      .pvalid_in  (pvalid_in),
      .win_out    (win_q[i]),
      .pat_out    (pat_q[i]),
      .pvalid_out (pvalid_q[i]),
      .hit        (hits[i])
    );
  end

  assign match_all = &hits;

endmodule

FILE: rtl/core/chunked_byte_pattern_search.sv
// Top level of the chunked byte pattern search: sequencing, offsets and result stages.
// Depends on cbps_pkg and cbps_row.
//
// Accepts one request per clock: pattern bytes (after a clear) shift into a row of 64
// compare cells, and each haystack byte is checked against the whole pattern in the cycle
// it is accepted. Chunk position, byte count and end-of-search state update in that same
// cycle, so requests follow back to back. A result goes from its request to the decision
// register, then through the offset add with saturation into the output register; the
// request side only stalls while both result registers hold results not yet taken.
module chunked_byte_pattern_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [cbps_pkg::CfgW-1:0]     cfg_data,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [1:0]                    command,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    status,
  output logic [cbps_pkg::OffW-1:0]     match_offset
);

  logic [cbps_pkg::ChunkW-1:0] chunk_size;
  logic [cbps_pkg::OffW-1:0]   start_offset;

  logic [cbps_pkg::LenW-1:0]   len, len_next;
  logic [cbps_pkg::ChunkW-1:0] pos, pos_next;
  logic [cbps_pkg::OffW-1:0]   bc, bc_next;
  logic                        done, done_next;

  cbps_pkg::cell_ctrl_t        ctrl;
  logic                        match_all;

  logic                        accept;
  logic                        bad;
  logic [cbps_pkg::ChunkW:0]   posn;
  logic                        hit;
  logic [63:0]                 base;
  logic                        restart;
  logic                        emit;
  cbps_pkg::status_t           emit_status;
  logic [63:0]                 emit_base;

  logic                        s1_valid;
  cbps_pkg::status_t           s1_status;
  logic [63:0]                 s1_base;
  logic                        out_free;
  logic                        s1_move;
  logic [63:0]                 sum;
  cbps_pkg::status_t           out_status;

  cbps_row u_row (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .data_byte (data_byte),
    .match_all (match_all)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size   <= cbps_pkg::ChunkW'(4096);
      start_offset <= '0;
    end else if (cfg_write) begin
      case (cbps_pkg::reg_index_t'(cfg_index))
        cbps_pkg::REG_CHUNK_SIZE:   chunk_size   <= cfg_data[cbps_pkg::ChunkW-1:0];
        cbps_pkg::REG_START_OFFSET: start_offset <= cfg_data[cbps_pkg::OffW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !result_valid || result_ready;
  assign s1_move    = s1_valid && out_free;
  assign item_ready = !s1_valid || out_free;
  assign accept     = item_valid && item_ready;

  assign bad  = (len == '0) || (cbps_pkg::ChunkW'(len) > chunk_size);
  assign posn = {1'b0, pos} + (cbps_pkg::ChunkW+1)'(1);
  assign hit  = ((cbps_pkg::ChunkW+1)'(len) <= posn) && match_all;
  assign base = {1'b0, bc} + 64'd1 - 64'(len);

  always_comb begin
    ctrl        = '0;
    len_next    = len;
    pos_next    = pos;
    bc_next     = bc;
    done_next   = done;
    restart     = 1'b0;
    emit        = 1'b0;
    emit_status = cbps_pkg::ST_MATCH;
    emit_base   = '0;
    if (accept) begin
      case (cbps_pkg::cmd_t'(command))
        cbps_pkg::CMD_CLEAR: begin
          ctrl.pat_clear = 1'b1;
          len_next       = '0;
          restart        = 1'b1;
        end
        cbps_pkg::CMD_APPEND: begin
          if (len < cbps_pkg::LenW'(cbps_pkg::MaxPattern)) begin
            ctrl.pat_shift = 1'b1;
            len_next       = len + 1'b1;
          end
        end
        cbps_pkg::CMD_HAYSTACK: begin
          if (done) begin
            restart = last_byte;
          end else if (bad) begin
            emit        = 1'b1;
            emit_status = cbps_pkg::ST_BAD;
            if (last_byte) restart = 1'b1;
            else           done_next = 1'b1;
          end else begin
            ctrl.win_shift = 1'b1;
            if (hit) begin
              emit        = 1'b1;
              emit_status = cbps_pkg::ST_MATCH;
              emit_base   = base;
              if (last_byte) restart = 1'b1;
              else           done_next = 1'b1;
            end else begin
              if (bc != cbps_pkg::OffMax) bc_next = bc + 1'b1;
              if (posn >= {1'b0, chunk_size}) pos_next = '0;
              else                            pos_next = posn[cbps_pkg::ChunkW-1:0];
              if (last_byte) begin
                emit        = 1'b1;
                emit_status = cbps_pkg::ST_NOMATCH;
                restart     = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (restart) begin
      pos_next  = '0;
      bc_next   = '0;
      done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      pos  <= '0;
      bc   <= '0;
      done <= 1'b0;
    end else begin
      len  <= len_next;
      pos  <= pos_next;
      bc   <= bc_next;
      done <= done_next;
    end
  end

  // decision register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (emit) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_status <= emit_status;
      s1_base   <= emit_base;
    end
  end

  // offset add with saturation
  assign sum = {1'b0, start_offset} + s1_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status <= s1_status;
      if (s1_status != cbps_pkg::ST_MATCH) match_offset <= '0;
      else if (sum[63])                    match_offset <= cbps_pkg::OffMax;
      else                                 match_offset <= sum[cbps_pkg::OffW-1:0];
    end
  end

  assign status = out_status;

`ifndef SYNTHESIS
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (out_status != cbps_pkg::ST_MATCH) |-> match_offset == '0)
    else $error("nonzero offset on a non-match result");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> s1_valid && result_valid)
    else $error("request side stalled with a free result stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_status) && $stable(s1_base))
    else $error("decision register lost a pending result");

  a_bad_pattern: assert property (@(posedge clk) disable iff (rst)
    accept && (command == cbps_pkg::CMD_HAYSTACK) && !done && (len == '0)
    |=> s1_valid && (s1_status == cbps_pkg::ST_BAD))
    else $error("empty pattern did not report an error");
`endif

endmodule

FILE: bench/cbps_search_checker.sv
`timescale 1ns / 100ps
// Checker for chunked_byte_pattern_search: watches register writes, requests and results,
// predicts every search result and compares it with what the block returns. Needs cbps_pkg.
module cbps_search_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [cbps_pkg::CfgW-1:0] cfg_data,
  input  logic                      item_valid,
  input  logic                      item_ready,
  input  logic [1:0]                command,
  input  logic [7:0]                data_byte,
  input  logic                      last_byte,
  input  logic                      result_valid,
  input  logic                      result_ready,
  input  logic [1:0]                status,
  input  logic [cbps_pkg::OffW-1:0] match_offset,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic [1:0]                st;
    logic [cbps_pkg::OffW-1:0] off;
  } search_result_t;

  search_result_t              awaited_q [$];
  logic [7:0]                  pat_bytes [cbps_pkg::MaxPattern];
  logic [7:0]                  recent [cbps_pkg::MaxPattern];
  int unsigned                 pat_len;
  logic [cbps_pkg::ChunkW-1:0] chunk_pos;
  logic [cbps_pkg::OffW-1:0]   byte_count;
  logic                        halted;
  logic [cbps_pkg::ChunkW-1:0] chunk_size_r;
  logic [cbps_pkg::OffW-1:0]   start_off_r;
  int                          shown;

  task automatic restart_scan();
    for (int i = 0; i < cbps_pkg::MaxPattern; i++) recent[i] = 8'h00;
    chunk_pos  = '0;
    byte_count = '0;
    halted     = 1'b0;
  endtask

  task automatic push_result(input cbps_pkg::status_t st,
                             input logic [cbps_pkg::OffW-1:0] off);
    search_result_t r;
    r.st  = st;
    r.off = off;
    awaited_q.push_back(r);
  endtask

  task automatic scan_request(input logic [1:0] cmd, input logic [7:0] b, input logic last);
    logic [63:0] posn;
    logic [63:0] total;
    logic        hit;
    case (cmd)
      cbps_pkg::CMD_CLEAR: begin
        pat_len = 0;
        restart_scan();
      end
      cbps_pkg::CMD_APPEND: begin
        if (pat_len < cbps_pkg::MaxPattern) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end
      end
      cbps_pkg::CMD_HAYSTACK: begin
        if (halted) begin
          if (last) restart_scan();
        end else if (pat_len == 0 || 64'(pat_len) > 64'(chunk_size_r)) begin
          push_result(cbps_pkg::ST_BAD, '0);
          if (last) restart_scan();
          else halted = 1'b1;
        end else begin
          for (int i = cbps_pkg::MaxPattern - 1; i > 0; i--) recent[i] = recent[i-1];
          recent[0] = b;
          posn = 64'(chunk_pos) + 64'd1;
          hit = (64'(pat_len) <= posn);
          for (int i = 0; i < pat_len; i++) begin
            if (recent[i] != pat_bytes[pat_len-1-i]) hit = 1'b0;
          end
          if (hit) begin
            total = 64'(byte_count) + 64'd1 - 64'(pat_len) + 64'(start_off_r);
            if (total > 64'(cbps_pkg::OffMax)) total = 64'(cbps_pkg::OffMax);
            push_result(cbps_pkg::ST_MATCH, total[cbps_pkg::OffW-1:0]);
            if (last) restart_scan();
            else halted = 1'b1;
          end else begin
            if (byte_count != cbps_pkg::OffMax) byte_count++;
            if (posn >= 64'(chunk_size_r)) begin
              chunk_pos = '0;
              for (int i = 0; i < cbps_pkg::MaxPattern; i++) recent[i] = 8'h00;
            end else begin
              chunk_pos = posn[cbps_pkg::ChunkW-1:0];
            end
            if (last) begin
              push_result(cbps_pkg::ST_NOMATCH, '0);
              restart_scan();
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    search_result_t want;
    if (awaited_q.size() == 0) begin
      fail_count++;
      if (shown < 10) begin
        shown++;
        $display("%0t: unexpected result status=%0d offset=%0d", $time, status, match_offset);
      end
    end else begin
      want = awaited_q.pop_front();
      if (status !== want.st || match_offset !== want.off) begin
        fail_count++;
        if (shown < 10) begin
          shown++;
          $display("%0t: result mismatch status exp=%0d got=%0d offset exp=%0d got=%0d",
                   $time, want.st, status, want.off, match_offset);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chunk_size_r = 32'd4096;
      start_off_r  = '0;
      pat_len      = 0;
      for (int i = 0; i < cbps_pkg::MaxPattern; i++) pat_bytes[i] = 8'h00;
      restart_scan();
      awaited_q.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      // results are registered after their request, so check before predicting
      if (result_valid && result_ready) check_result();
      if (item_valid && item_ready) scan_request(command, data_byte, last_byte);
      if (cfg_write) begin
        if (cfg_index == cbps_pkg::REG_CHUNK_SIZE) chunk_size_r = cfg_data[cbps_pkg::ChunkW-1:0];
        else start_off_r = cfg_data[cbps_pkg::OffW-1:0];
      end
    end
    outstanding = awaited_q.size();
  end

endmodule

FILE: bench/chunked_byte_pattern_search_tb.sv
`timescale 1ns / 100ps
// Stimulus top for chunked_byte_pattern_search: clock, reset, register writes and request
// traffic under idle and stall phases. Needs cbps_pkg, the block and cbps_search_checker.
module chunked_byte_pattern_search_tb;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int         PhaseCount  = 8;
  localparam int         RandomItems = 1900;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      cfg_write    = 1'b0;
  logic [0:0]                cfg_index    = '0;
  logic [cbps_pkg::CfgW-1:0] cfg_data     = '0;
  logic                      item_valid   = 1'b0;
  logic                      item_ready;
  logic [1:0]                command      = cbps_pkg::CMD_CLEAR;
  logic [7:0]                data_byte    = 8'h00;
  logic                      last_byte    = 1'b0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [1:0]                status;
  logic [cbps_pkg::OffW-1:0] match_offset;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int sent_count     = 0;

  chunked_byte_pattern_search u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .match_offset (match_offset)
  );

  cbps_search_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .match_offset (match_offset),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    command    <= cmd;
    data_byte  <= b;
    last_byte  <= last;
    do @(posedge clk); while (!item_ready);
    if (cmd != CMD_UNKNOWN) sent_count++;
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input cbps_pkg::reg_index_t idx,
                           input logic [cbps_pkg::CfgW-1:0] value);
    @(negedge clk);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic search_round();
    logic [7:0] letters [4];
    logic [7:0] pat [$];
    logic [7:0] hay [$];
    int         n_letters;
    int         plen;
    int         r;
    int         append_at;
    logic       drop_last;
    r = $urandom_range(99);
    if (r >= 82) begin
      repeat ($urandom_range(1, 8))
        send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
    end else begin
      n_letters = $urandom_range(1, 4);
      foreach (letters[i]) begin
        case ($urandom_range(3))
          0:       letters[i] = 8'h00;
          1:       letters[i] = 8'hFF;
          default: letters[i] = 8'($urandom_range(0, 255));
        endcase
      end
      if ($urandom_range(99) >= 15) begin
        r = $urandom_range(99);
        plen = (r < 85) ? $urandom_range(1, 5) :
               (r < 96) ? $urandom_range(6, 16) : $urandom_range(60, 70);
        send_req(cbps_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (plen) begin
          pat.push_back(letters[$urandom_range(0, n_letters - 1)]);
          send_req(cbps_pkg::CMD_APPEND, pat[$], 1'($urandom_range(0, 1)));
        end
      end
      repeat ($urandom_range(0, 12)) hay.push_back(letters[$urandom_range(0, n_letters - 1)]);
      if ($urandom_range(1) == 1) begin
        foreach (pat[i]) if (i < cbps_pkg::MaxPattern) hay.push_back(pat[i]);
      end
      repeat ($urandom_range(0, 12)) hay.push_back(letters[$urandom_range(0, n_letters - 1)]);
      if (hay.size() == 0) hay.push_back(letters[0]);
      append_at = ($urandom_range(99) < 8) ? $urandom_range(0, hay.size() - 1) : -1;
      drop_last = ($urandom_range(99) < 10);
      foreach (hay[i]) begin
        if (i == append_at)
          send_req(cbps_pkg::CMD_APPEND, letters[$urandom_range(0, n_letters - 1)], 1'b0);
        send_req(cbps_pkg::CMD_HAYSTACK, hay[i], (i == hay.size() - 1) && !drop_last);
      end
    end
  endtask

  initial begin
    int                          target;
    logic [cbps_pkg::OffW-1:0]   rnd_off;
    logic [cbps_pkg::ChunkW-1:0] chunk;
    logic [cbps_pkg::OffW-1:0]   off;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern, halted search, unknown command
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b1);
    send_req(CMD_UNKNOWN, 8'hA5, 1'b1);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h12, 1'b1);
    send_req(cbps_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_APPEND, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_APPEND, 8'hFF, 1'b1);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b1);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h55, 1'b1);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b1);

    // chunk boundary and offset saturation
    write_reg(cbps_pkg::REG_CHUNK_SIZE, {31'h7FFF_FFFF, 32'd2});
    write_reg(cbps_pkg::REG_START_OFFSET, cbps_pkg::OffMax);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h11, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'hFF, 1'b1);

    // pattern longer than chunk, append mid-stream
    write_reg(cbps_pkg::REG_CHUNK_SIZE, 63'd1);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h00, 1'b1);
    send_req(cbps_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send_req(cbps_pkg::CMD_APPEND, 8'h07, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h01, 1'b0);
    send_req(cbps_pkg::CMD_APPEND, 8'h08, 1'b0);
    send_req(cbps_pkg::CMD_HAYSTACK, 8'h08, 1'b1);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      rnd_off = cbps_pkg::OffW'({$urandom, $urandom});
      case (ph)
        0: begin chunk = 32'd4096;       off = '0; end
        1: begin chunk = 32'd1;          off = rnd_off; end
        2: begin chunk = 32'd3;          off = cbps_pkg::OffMax; end
        3: begin
          chunk = 32'hFFFF_FFFF;
          off   = cbps_pkg::OffMax - cbps_pkg::OffW'($urandom_range(0, 40));
        end
        4: begin chunk = 32'd8;          off = rnd_off; end
        5: begin chunk = 32'd0;          off = '0; end
        6: begin chunk = 32'd5;          off = rnd_off; end
        default: begin chunk = 32'd64;   off = '0; end
      endcase
      write_reg(cbps_pkg::REG_CHUNK_SIZE, {31'($urandom), chunk});
      write_reg(cbps_pkg::REG_START_OFFSET, off);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      target = sent_count + RandomItems / PhaseCount;
      if (ph == 0) begin
        // long receiver hold-off while every request yields a result
        send_req(cbps_pkg::CMD_CLEAR, 8'h00, 1'b0);
        send_req(cbps_pkg::CMD_APPEND, 8'h3C, 1'b0);
        hold_left = 300;
        repeat (60)
          send_req(cbps_pkg::CMD_HAYSTACK,
                   ($urandom_range(1) != 0) ? 8'h3C : 8'($urandom_range(0, 255)), 1'b1);
      end
      while (sent_count < target) search_round();
    end

    @(negedge clk);
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
